// ===== hdl/obi_pkg.sv =====
`default_nettype none

package obi_pkg;

	// Field widths fixed by the item format
	localparam int unsigned COORD_W   = 32;
	localparam int unsigned MARGIN_W  = 30;
	localparam int unsigned ID_W      = 4;
	localparam int unsigned FUNC_W    = 2;
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned CFG_DAT_W = 32;

	// Object slots addressable by an id, and the cap on query hits
	localparam int unsigned ID_SLOTS    = 16;
	localparam int unsigned MAX_RESULTS = 16;
	localparam int unsigned HIT_CNT_W   = 5;

	// Operation codes; the reserved code is acknowledged and changes nothing
	localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_QUERY  = 2'd2;
	localparam logic [FUNC_W-1:0] FUNC_RSVD   = 2'd3;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_BOX_LOW_X  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BOX_LOW_Y  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BOX_LOW_Z  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_BOX_HIGH_X = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_BOX_HIGH_Y = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_BOX_HIGH_Z = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_MARGIN     = 3'd6;

	typedef enum logic [3:0] {
		S_RST_CLR,
		S_IDLE,
		S_CLR,
		S_ACK,
		S_DESC,
		S_INS_RD,
		S_INS_WR,
		S_Q_LVL,
		S_Q_HEAD,
		S_Q_WALK,
		S_Q_FIN
	} state_t;

	typedef struct packed {
		logic accept;
		logic clr_step;
		logic desc_step;
		logic ins_write;
		logic q_level;
		logic q_head;
		logic walk_step;
		logic next_level;
		logic emit_ack;
		logic emit_final;
	} cmd_t;

	typedef struct packed {
		logic              req_valid;
		logic [FUNC_W-1:0] req_func;
		logic              req_id_ok;
		logic              clr_done;
		logic              desc_stop;
		logic              walk_more;
		logic              emit_blocked;
		logic              last_level;
		logic              out_free;
	} status_t;

endpackage

`default_nettype wire

// ===== hdl/obi_if.sv =====
`default_nettype none

interface obi_req_if;
	logic                                 valid;
	logic                                 ready;
	logic [obi_pkg::FUNC_W-1:0]           func;
	logic signed [obi_pkg::COORD_W-1:0]   pos_x;
	logic signed [obi_pkg::COORD_W-1:0]   pos_y;
	logic signed [obi_pkg::COORD_W-1:0]   pos_z;
	logic [obi_pkg::ID_W-1:0]             object_id;

	modport source (output valid, func, pos_x, pos_y, pos_z, object_id, input ready);
	modport sink (input valid, func, pos_x, pos_y, pos_z, object_id, output ready);
endinterface

interface obi_rsp_if;
	logic                     valid;
	logic                     ready;
	logic [obi_pkg::ID_W-1:0] hit_id;
	logic                     hit_valid;
	logic                     last;

	modport source (output valid, hit_id, hit_valid, last, input ready);
	modport sink (input valid, hit_id, hit_valid, last, output ready);
endinterface

`default_nettype wire

// ===== hdl/obi_ctrl.sv =====
`default_nettype none

module obi_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire obi_pkg::status_t status,
	output obi_pkg::cmd_t         cmd,
	output logic                  ready
);

	obi_pkg::state_t state_q;
	obi_pkg::state_t state_nx;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= obi_pkg::S_RST_CLR;
		end else begin
			state_q <= state_nx;
		end
	end

	// Next state and commands
	always_comb begin
		state_nx = state_q;
		cmd      = '0;
		ready    = 1'b0;
		case (state_q)
			obi_pkg::S_RST_CLR: begin
				cmd.clr_step = 1'b1;
				if (status.clr_done) state_nx = obi_pkg::S_IDLE;
			end
			obi_pkg::S_IDLE: begin
				ready = 1'b1;
				if (status.req_valid) begin
					cmd.accept = 1'b1;
					case (status.req_func)
						obi_pkg::FUNC_CLEAR:  state_nx = obi_pkg::S_CLR;
						obi_pkg::FUNC_INSERT: begin
							state_nx = status.req_id_ok ? obi_pkg::S_DESC : obi_pkg::S_ACK;
						end
						obi_pkg::FUNC_QUERY:  state_nx = obi_pkg::S_Q_LVL;
						default:              state_nx = obi_pkg::S_ACK;
					endcase
				end
			end
			obi_pkg::S_CLR: begin
				cmd.clr_step = 1'b1;
				if (status.clr_done) state_nx = obi_pkg::S_ACK;
			end
			obi_pkg::S_ACK: begin
				if (status.out_free) begin
					cmd.emit_ack = 1'b1;
					state_nx     = obi_pkg::S_IDLE;
				end
			end
			obi_pkg::S_DESC: begin
				cmd.desc_step = 1'b1;
				if (status.desc_stop) state_nx = obi_pkg::S_INS_RD;
			end
			obi_pkg::S_INS_RD: begin
				state_nx = obi_pkg::S_INS_WR;
			end
			obi_pkg::S_INS_WR: begin
				cmd.ins_write = 1'b1;
				state_nx      = obi_pkg::S_ACK;
			end
			obi_pkg::S_Q_LVL: begin
				cmd.q_level = 1'b1;
				state_nx    = obi_pkg::S_Q_HEAD;
			end
			obi_pkg::S_Q_HEAD: begin
				cmd.q_head = 1'b1;
				state_nx   = obi_pkg::S_Q_WALK;
			end
			obi_pkg::S_Q_WALK: begin
				if (status.walk_more) begin
					if (!status.emit_blocked) cmd.walk_step = 1'b1;
				end else if (status.last_level) begin
					state_nx = obi_pkg::S_Q_FIN;
				end else begin
					cmd.next_level = 1'b1;
					state_nx       = obi_pkg::S_Q_LVL;
				end
			end
			obi_pkg::S_Q_FIN: begin
				if (status.out_free) begin
					cmd.emit_final = 1'b1;
					state_nx       = obi_pkg::S_IDLE;
				end
			end
			default: begin
				state_nx = obi_pkg::S_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

// ===== hdl/obi_datapath.sv =====
`default_nettype none

module obi_datapath #(
	parameter int unsigned TREE_DEPTH  = 3,
	parameter int unsigned MAX_OBJECTS = 16,
	parameter int unsigned NODE_COUNT  = 585
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire obi_pkg::cmd_t                     cmd,
	output obi_pkg::status_t                       status,
	obi_req_if.sink                                req,
	obi_rsp_if.source                              rsp,
	input  wire logic                              cfg_we,
	input  wire logic [obi_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [obi_pkg::CFG_DAT_W-1:0]     cfg_data
);

	localparam int unsigned NW = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
	localparam int unsigned CW = NW + 4;
	localparam int unsigned DW = $clog2(TREE_DEPTH + 1);
	localparam int unsigned SW = $clog2(MAX_OBJECTS + 1);
	localparam int unsigned EW = obi_pkg::COORD_W + 2;
	localparam int unsigned IW = obi_pkg::ID_W;
	localparam int unsigned LW = obi_pkg::ID_W + 1;

	// Configuration registers
	logic signed [obi_pkg::COORD_W-1:0] box_lo_q [3];
	logic signed [obi_pkg::COORD_W-1:0] box_hi_q [3];
	logic [obi_pkg::MARGIN_W-1:0]       margin_q;

	// Item and descent state
	logic [obi_pkg::FUNC_W-1:0]         func_q;
	logic [IW-1:0]                      id_q;
	logic signed [obi_pkg::COORD_W-1:0] lo_q [3];
	logic signed [obi_pkg::COORD_W-1:0] hi_q [3];
	logic signed [EW-1:0]               bmin_q [3];
	logic signed [EW-1:0]               bmax_q [3];
	logic [NW-1:0]                      node_q;
	logic [DW-1:0]                      depth_q;
	logic [2:0]                         w_q;
	logic [5:0]                         sides_q;
	logic [NW-1:0]                      clr_q;

	// Node list heads and object links
	logic [LW-1:0] head_mem [NODE_COUNT];
	logic [LW-1:0] rd_q;
	logic [LW-1:0] obj_next_q [obi_pkg::ID_SLOTS];
	logic [5:0]    obj_sides_q [obi_pkg::ID_SLOTS];

	// List walk and result staging
	logic                           walk_has_q;
	logic [IW-1:0]                  walk_idx_q;
	logic [SW-1:0]                  steps_q;
	logic [obi_pkg::HIT_CNT_W-1:0]  n_q;
	logic                           pend_valid_q;
	logic [IW-1:0]                  pend_id_q;
	logic                           out_valid_q;
	logic [IW-1:0]                  out_id_q;
	logic                           out_hit_q;
	logic                           out_last_q;

	logic signed [obi_pkg::COORD_W:0]   mid_sum [3];
	logic signed [obi_pkg::COORD_W-1:0] mid_c [3];
	logic signed [EW-1:0]               mid_c_ext [3];
	logic [2:0]                         lower;
	logic [2:0]                         upper_ins;
	logic [2:0]                         go_up;
	logic                               straddle;
	logic [CW-1:0]                      child_lvl;
	logic [CW-1:0]                      child_w;
	logic                               is_query;
	logic [5:0]                         cur_sides;
	logic                               excl;
	logic                               cand;
	logic                               out_free;
	logic                               walk_more;
	logic [obi_pkg::COORD_W-1:0]        req_pos [3];
	logic [EW-1:0]                      ext;
	logic                               mem_we;
	logic [NW-1:0]                      mem_waddr;
	logic [LW-1:0]                      mem_wdata;

	assign is_query   = (func_q == obi_pkg::FUNC_QUERY);
	assign req_pos[0] = req.pos_x;
	assign req_pos[1] = req.pos_y;
	assign req_pos[2] = req.pos_z;

	// Midpoint and side tests per axis
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			mid_sum[i]   = {lo_q[i][obi_pkg::COORD_W-1], lo_q[i]}
				+ {hi_q[i][obi_pkg::COORD_W-1], hi_q[i]};
			mid_c[i]     = mid_sum[i][obi_pkg::COORD_W:1];
			mid_c_ext[i] = {{2{mid_c[i][obi_pkg::COORD_W-1]}}, mid_c[i]};
			lower[i]     = (bmax_q[i] < mid_c_ext[i]);
			upper_ins[i] = (bmin_q[i] > mid_c_ext[i]);
			go_up[i]     = is_query ? !lower[i] : upper_ins[i];
		end
	end

	assign straddle  = |(~lower & ~upper_ins);
	assign child_lvl = ({4'b0, node_q} << 3) + CW'(1) + CW'(go_up);
	assign child_w   = ({4'b0, node_q} << 3) + CW'(1) + CW'(w_q);
	assign cur_sides = {upper_ins[2], lower[2], upper_ins[1], lower[1], upper_ins[0], lower[0]};

	// Exclusion test of the listed object against the point's octant
	assign excl = |(w_q & {obj_sides_q[walk_idx_q][4], obj_sides_q[walk_idx_q][2],
		obj_sides_q[walk_idx_q][0]})
		| |(~w_q & {obj_sides_q[walk_idx_q][5], obj_sides_q[walk_idx_q][3],
		obj_sides_q[walk_idx_q][1]});
	assign cand      = !excl && (n_q < obi_pkg::HIT_CNT_W'(obi_pkg::MAX_RESULTS));
	assign walk_more = walk_has_q && (steps_q < SW'(MAX_OBJECTS))
		&& (32'(walk_idx_q) < MAX_OBJECTS);
	assign out_free  = !out_valid_q || rsp.ready;

	// Status toward the controller
	always_comb begin
		status              = '0;
		status.req_valid    = req.valid;
		status.req_func     = req.func;
		status.req_id_ok    = (32'(req.object_id) < MAX_OBJECTS);
		status.clr_done     = (clr_q == NW'(NODE_COUNT - 1));
		status.desc_stop    = straddle || (32'(depth_q) >= TREE_DEPTH)
			|| (child_lvl >= CW'(NODE_COUNT));
		status.walk_more    = walk_more;
		status.emit_blocked = cand && pend_valid_q && !out_free;
		status.last_level   = (32'(depth_q) >= TREE_DEPTH) || (child_w >= CW'(NODE_COUNT));
		status.out_free     = out_free;
	end

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				box_lo_q[i] <= '0;
				box_hi_q[i] <= '0;
			end
			margin_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				obi_pkg::REG_BOX_LOW_X:  box_lo_q[0] <= cfg_data;
				obi_pkg::REG_BOX_LOW_Y:  box_lo_q[1] <= cfg_data;
				obi_pkg::REG_BOX_LOW_Z:  box_lo_q[2] <= cfg_data;
				obi_pkg::REG_BOX_HIGH_X: box_hi_q[0] <= cfg_data;
				obi_pkg::REG_BOX_HIGH_Y: box_hi_q[1] <= cfg_data;
				obi_pkg::REG_BOX_HIGH_Z: box_hi_q[2] <= cfg_data;
				obi_pkg::REG_MARGIN:     margin_q <= cfg_data[obi_pkg::MARGIN_W-1:0];
				default: ;
			endcase
		end
	end

	// Inserted box grows by twice the margin; a query point has no extent
	assign ext = (req.func == obi_pkg::FUNC_INSERT) ? {3'b0, margin_q, 1'b0} : '0;

	// Load the item, then narrow the cell one level at a time
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			func_q <= req.func;
			id_q   <= req.object_id;
			for (int i = 0; i < 3; i++) begin
				lo_q[i]   <= box_lo_q[i];
				hi_q[i]   <= box_hi_q[i];
				bmin_q[i] <= {{2{req_pos[i][obi_pkg::COORD_W-1]}}, req_pos[i]} - ext;
				bmax_q[i] <= {{2{req_pos[i][obi_pkg::COORD_W-1]}}, req_pos[i]} + ext;
			end
		end else if (cmd.desc_step || cmd.q_level) begin
			for (int i = 0; i < 3; i++) begin
				if (lower[i]) begin
					hi_q[i] <= mid_c[i];
				end else if (go_up[i]) begin
					lo_q[i] <= mid_c[i];
				end
			end
		end
		if (cmd.desc_step) sides_q <= cur_sides;
		if (cmd.q_level) w_q <= go_up;
	end

	// Node pointer and depth
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_q  <= '0;
			depth_q <= '0;
		end else if (cmd.accept) begin
			node_q  <= '0;
			depth_q <= '0;
		end else if (cmd.desc_step && !status.desc_stop) begin
			node_q  <= child_lvl[NW-1:0];
			depth_q <= depth_q + DW'(1);
		end else if (cmd.next_level) begin
			node_q  <= child_w[NW-1:0];
			depth_q <= depth_q + DW'(1);
		end
	end

	// Clear sweep address
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.clr_step) begin
			clr_q <= status.clr_done ? '0 : clr_q + NW'(1);
		end
	end

	// List head memory: one write port, registered read at the current node
	assign mem_we    = cmd.clr_step || cmd.ins_write;
	assign mem_waddr = cmd.clr_step ? clr_q : node_q;
	assign mem_wdata = cmd.clr_step ? '0 : {1'b1, id_q};

	always_ff @(posedge clk) begin
		if (mem_we) head_mem[mem_waddr] <= mem_wdata;
		rd_q <= head_mem[node_q];
	end

	// Push the object onto the front of its node's list
	always_ff @(posedge clk) begin
		if (cmd.ins_write) begin
			obj_next_q[id_q]  <= rd_q;
			obj_sides_q[id_q] <= sides_q;
		end
	end

	// Walk the list of the current node
	always_ff @(posedge clk) begin
		if (cmd.q_head) begin
			walk_has_q <= rd_q[LW-1];
			walk_idx_q <= rd_q[IW-1:0];
			steps_q    <= '0;
		end else if (cmd.walk_step) begin
			walk_has_q <= obj_next_q[walk_idx_q][LW-1];
			walk_idx_q <= obj_next_q[walk_idx_q][IW-1:0];
			steps_q    <= steps_q + SW'(1);
		end
	end

	// Hold back one candidate so the final one can carry last
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_valid_q <= 1'b0;
			n_q          <= '0;
		end else if (cmd.accept || cmd.emit_final) begin
			pend_valid_q <= 1'b0;
			n_q          <= '0;
		end else if (cmd.walk_step && cand) begin
			pend_valid_q <= 1'b1;
			n_q          <= n_q + obi_pkg::HIT_CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.walk_step && cand) pend_id_q <= walk_idx_q;
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			out_id_q    <= '0;
			out_hit_q   <= 1'b0;
			out_last_q  <= 1'b0;
		end else if (cmd.emit_ack || (cmd.emit_final && !pend_valid_q)) begin
			out_valid_q <= 1'b1;
			out_id_q    <= '0;
			out_hit_q   <= 1'b0;
			out_last_q  <= 1'b1;
		end else if (cmd.emit_final) begin
			out_valid_q <= 1'b1;
			out_id_q    <= pend_id_q;
			out_hit_q   <= 1'b1;
			out_last_q  <= 1'b1;
		end else if (cmd.walk_step && cand && pend_valid_q) begin
			out_valid_q <= 1'b1;
			out_id_q    <= pend_id_q;
			out_hit_q   <= 1'b1;
			out_last_q  <= 1'b0;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign rsp.valid     = out_valid_q;
	assign rsp.hit_id    = out_id_q;
	assign rsp.hit_valid = out_hit_q;
	assign rsp.last      = out_last_q;

endmodule

`default_nettype wire

// ===== hdl/octree_broadphase_index_core.sv =====
`default_nettype none

// Fixed-depth octree broad-phase index in signed Q16.16. One item is in work at a time;
// a new item is taken while the previous result still waits in the output register.
// Clear sweeps the list-head memory one node per cycle, and the same sweep runs after
// reset before the first item is taken. Insert descends one tree level at a time, then
// reads the node's list head and pushes the object onto the front of that list.
// Query visits one level at a time: it narrows the cell, reads the list head, then
// walks the listed objects; a hit stalls the walk while the output side is not free.
module octree_broadphase_index_core #(
	parameter int unsigned TREE_DEPTH  = 3,
	parameter int unsigned MAX_OBJECTS = 16,
	parameter int unsigned NODE_COUNT  = 585
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	obi_req_if.sink                            req,
	obi_rsp_if.source                          rsp,
	input  wire logic                          cfg_we,
	input  wire logic [obi_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [obi_pkg::CFG_DAT_W-1:0] cfg_data
);

	obi_pkg::cmd_t    cmd;
	obi_pkg::status_t status;
	logic             ready;

	assign req.ready = ready;

	obi_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.status (status),
		.cmd    (cmd),
		.ready  (ready)
	);

	obi_datapath #(
		.TREE_DEPTH  (TREE_DEPTH),
		.MAX_OBJECTS (MAX_OBJECTS),
		.NODE_COUNT  (NODE_COUNT)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.req       (req),
		.rsp       (rsp),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// One item at a time: no second transfer right after an accepted one
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> !req.ready)
		else $error("input accepted while previous item still in work");

	// Acknowledgements and empty queries carry id zero
	a_ack_id: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && !rsp.hit_valid |-> rsp.hit_id == '0)
		else $error("non-hit result with nonzero id");

	// A non-hit result always ends its item
	a_ack_last: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && !rsp.hit_valid |-> rsp.last)
		else $error("non-hit result without last");

endmodule

`default_nettype wire
